### design/adt_pkg.sv
// adt_pkg: shared widths, command and status codes, and the request token
// that travels along the descriptor cell chain. No dependencies.
package adt_pkg;

    localparam int ADT_ENTRIES     = 64;
    localparam int ADT_ADDR_W      = 32;
    localparam int ADT_SIZE_W      = 21;
    localparam int ADT_STATUS_W    = 2;

    // commands
    localparam logic CMD_RECORD  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result status codes
    localparam logic [ADT_STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [ADT_STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ADT_STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ADT_STATUS_W-1:0] ST_ZERO_SIZE = 2'd3;

    // request in flight; size carries the record size, or the released
    // page count once a release has hit
    typedef struct packed {
        logic                    valid;
        logic                    command;
        logic                    done;
        logic [ADT_STATUS_W-1:0] status;
        logic [ADT_ADDR_W-1:0]   address;
        logic [ADT_SIZE_W-1:0]   size;
    } adt_token_t;

endpackage

### design/adt_cell.sv
// adt_cell: one descriptor entry plus one stage of the request chain.
// Depends on adt_pkg.
module adt_cell
    import adt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  adt_token_t tok_in,
    output adt_token_t tok_out
);

    logic [ADT_ADDR_W-1:0] addr_reg;
    logic [ADT_SIZE_W-1:0] size_reg;
    adt_token_t            tok_reg;
    adt_token_t            tok_next;
    logic                  entry_free;
    logic                  hit_record;
    logic                  hit_release;

    // an entry is free when its page count is zero
    assign entry_free  = (size_reg == '0);
    assign hit_record  = tok_in.valid && !tok_in.done && (tok_in.command == CMD_RECORD)
                         && entry_free;
    assign hit_release = tok_in.valid && !tok_in.done && (tok_in.command == CMD_RELEASE)
                         && !entry_free && (addr_reg == tok_in.address);

    // update the passing request
    always_comb begin
        tok_next = tok_in;
        if (hit_record) begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
        end
        if (hit_release) begin
            tok_next.done   = 1'b1;
            tok_next.status = ST_OK;
            tok_next.size   = size_reg;
        end
    end

    // entry storage; address needs no reset, a free entry never compares
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '0;
        end else if (advance) begin
            if (hit_record) begin
                size_reg <= tok_in.size;
            end else if (hit_release) begin
                size_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && hit_record) begin
            addr_reg <= tok_in.address;
        end
    end

    // hand the request to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### design/allocation_descriptor_table_unit.sv
// Allocation descriptor table: top level, a chain of ENTRIES adt_cell
// instances followed by the result register. Depends on adt_pkg, adt_cell.
//
// Usage:
//   Input channel s_*: one request per accepted item. s_command 0 records
//   s_address/s_size into the lowest-index free entry, 1 releases the
//   lowest-index valid entry holding s_address.
//   Result channel m_*: exactly one result per request, in request order:
//   m_status (0 ok, 1 full, 2 not found, 3 zero size) and m_released_size.
//   Path: each request passes the ENTRIES cell registers of the chain,
//   then the result register, moving one entry per cycle while the
//   receiver does not stall, so the chain length sets the latency.
//   Throughput: one request per cycle unless a held result stalls the chain;
//   requests follow each other down the chain, each cell seeing them in order.
//   Stall: while a result waits and m_ready is low, the whole chain and
//   s_ready freeze; nothing is lost or reordered.
//   Reset (aresetn low, synchronous): all entries become free, the chain
//   and the result register empty. No clearing pass is needed.
module allocation_descriptor_table_unit
    import adt_pkg::*;
#(
    parameter int ENTRIES = ADT_ENTRIES
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [ADT_ADDR_W-1:0]   s_address,
    input  logic [ADT_SIZE_W-1:0]   s_size,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ADT_STATUS_W-1:0] m_status,
    output logic [ADT_SIZE_W-1:0]   m_released_size
);

    adt_token_t                tok [0:ENTRIES];
    logic                      advance;
    logic                      m_valid_reg;
    logic [ADT_STATUS_W-1:0]   m_status_reg;
    logic [ADT_STATUS_W-1:0]   m_status_next;
    logic [ADT_SIZE_W-1:0]     m_released_size_reg;
    logic [ADT_SIZE_W-1:0]     m_released_size_next;
    logic                      zero_record;

    // chain moves unless a result is held by the receiver
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // incoming request; a zero-size record is settled right here
    assign zero_record = (s_command == CMD_RECORD) && (s_size == '0);

    always_comb begin
        tok[0].valid   = s_valid;
        tok[0].command = s_command;
        tok[0].done    = zero_record;
        tok[0].status  = zero_record ? ST_ZERO_SIZE : ST_OK;
        tok[0].address = s_address;
        tok[0].size    = s_size;
    end

    // cell chain
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        adt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    // final status: a request nobody took is full or not found
    always_comb begin
        if (tok[ENTRIES].done) begin
            m_status_next = tok[ENTRIES].status;
        end else if (tok[ENTRIES].command == CMD_RELEASE) begin
            m_status_next = ST_NOT_FOUND;
        end else begin
            m_status_next = ST_FULL;
        end
        m_released_size_next = (tok[ENTRIES].done && tok[ENTRIES].command == CMD_RELEASE)
                               ? tok[ENTRIES].size : '0;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= tok[ENTRIES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_status_reg        <= m_status_next;
            m_released_size_reg <= m_released_size_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_released_size = m_released_size_reg;

endmodule

### design/adt_checker.sv
// adt_checker: port-level assertions for allocation_descriptor_table_unit,
// bound to the top level. Depends on adt_pkg.
module adt_checker
    import adt_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [ADT_STATUS_W-1:0] m_status,
    input logic [ADT_SIZE_W-1:0]   m_released_size
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_released_size)))
        else $error("result changed while stalled");

    // only a successful release returns pages
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_released_size == '0))
        else $error("pages returned on a failed request");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present right after reset");

    // input side is blocked only by a held result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a held result");

endmodule

bind allocation_descriptor_table_unit adt_checker u_adt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_released_size (m_released_size)
);
